// ===== sv/tcw_pkg.sv =====
// Shared types, codes and defaults for the text console write engine.
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] BS_COLOUR    = 8'd15;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_SETCUR = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_ACCESS,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t        opcode;
        logic [7:0] char_code;
        logic [7:0] colour;
        logic [6:0] column;
        logic [4:0] row;
    } cmd_t;

    typedef struct packed {
        logic [6:0] cursor_column;
        logic [4:0] cursor_row;
        logic [7:0] cell_char;
        logic [7:0] cell_colour;
        logic       scrolled;
    } rsp_t;

    // What one request does to the store
    typedef struct packed {
        logic wr;
        logic rd;
        logic sweep;
        logic scroll;
    } ctl_t;

endpackage

// ===== sv/text_console_write_engine.sv =====
// Text console write engine: top level with sequencer, sweep pipeline and cell RAM.
//
// A character write, newline, backspace, cursor set or cell read passes through
// accept, decode and address, RAM access and the response register. A clear
// screen, or a write that scrolls, walks every cell through the RAM's one read
// and one write port. After reset the block zeroes the cell RAM before
// cmd_ready first rises. One request is worked at a time; the response
// register lets the next request be taken while a response still waits on
// rsp_ready.
module text_console_write_engine #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  tcw_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output tcw_pkg::rsp_t rsp
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int XW    = $clog2(COLUMNS);
    localparam int YW    = $clog2(ROWS);
    localparam int IDX_W = $clog2(CELLS);

    tcw_pkg::state_t state_reg, state_next;

    tcw_pkg::cmd_t req_reg;
    tcw_pkg::ctl_t ctl_dec, ctl_reg;
    logic [IDX_W-1:0] addr_dec, addr_reg;
    logic [15:0]      wr_data_dec, wr_data_reg;
    logic [XW-1:0]    cur_x;
    logic [YW-1:0]    cur_y;

    logic [IDX_W-1:0] sweep_idx_reg, sweep_idx_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0] pend_addr_reg;
    logic             pend_zero_reg, pend_zero_next;
    logic [IDX_W:0]   src_sum;
    logic             src_in_range, sweep_last;

    tcw_pkg::rsp_t rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;
    logic          rsp_free, rsp_load, cursor_update;

    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [15:0]      ram_wdata, ram_rdata;

    tcw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (req_reg),
        .update  (cursor_update),
        .ctl     (ctl_dec),
        .addr    (addr_dec),
        .wr_data (wr_data_dec),
        .cur_x   (cur_x),
        .cur_y   (cur_y)
    );

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // scroll reads one row ahead of the write; beyond the store it fills zeros
    assign src_sum      = {1'b0, sweep_idx_reg} + (IDX_W + 1)'(COLUMNS);
    assign src_in_range = (src_sum < (IDX_W + 1)'(CELLS));
    assign sweep_last   = (sweep_idx_reg == IDX_W'(CELLS - 1));
    assign rsp_free     = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tcw_pkg::ST_INIT;
            sweep_idx_reg  <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_idx_reg  <= sweep_idx_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            req_reg <= cmd;
        end
        if (cursor_update)
        begin
            ctl_reg     <= ctl_dec;
            addr_reg    <= addr_dec;
            wr_data_reg <= wr_data_dec;
        end
        pend_addr_reg <= sweep_idx_reg;
        pend_zero_reg <= pend_zero_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                if (sweep_last)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = tcw_pkg::ST_DECODE;
                end
            end
            tcw_pkg::ST_DECODE:
            begin
                state_next = tcw_pkg::ST_ACCESS;
            end
            tcw_pkg::ST_ACCESS:
            begin
                state_next = ctl_reg.sweep ? tcw_pkg::ST_SWEEP : tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = tcw_pkg::ST_DRAIN;
                end
            end
            tcw_pkg::ST_DRAIN:
            begin
                state_next = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcw_pkg::ST_INIT;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        cmd_ready       = (state_reg == tcw_pkg::ST_IDLE);
        cursor_update   = (state_reg == tcw_pkg::ST_DECODE);
        sweep_idx_next  = sweep_idx_reg;
        pend_valid_next = (state_reg == tcw_pkg::ST_SWEEP);
        pend_zero_next  = ctl_reg.scroll && !src_in_range;
        rsp_load        = (state_reg == tcw_pkg::ST_DONE) && rsp_free;

        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = addr_reg;

        if ((state_reg == tcw_pkg::ST_INIT) || (state_reg == tcw_pkg::ST_SWEEP))
        begin
            sweep_idx_next = sweep_last ? '0 : sweep_idx_reg + IDX_W'(1);
        end

        if (state_reg == tcw_pkg::ST_INIT)
        begin
            ram_we    = 1'b1;
            ram_waddr = sweep_idx_reg;
        end
        else if ((state_reg == tcw_pkg::ST_ACCESS) && ctl_reg.wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = addr_reg;
            ram_wdata = wr_data_reg;
        end
        else if (pend_valid_reg)
        begin
            ram_we = 1'b1;
            if (ctl_reg.scroll)
            begin
                ram_wdata = pend_zero_reg ? 16'd0 : ram_rdata;
            end
            else
            begin
                ram_wdata = {ram_rdata[15:8], tcw_pkg::CH_SPACE};
            end
        end

        if ((state_reg == tcw_pkg::ST_ACCESS) && ctl_reg.rd)
        begin
            ram_re = 1'b1;
        end
        else if (state_reg == tcw_pkg::ST_SWEEP)
        begin
            ram_re    = !ctl_reg.scroll || src_in_range;
            ram_raddr = ctl_reg.scroll ? src_sum[IDX_W-1:0] : sweep_idx_reg;
        end

        // read data holds in the RAM output register until the response goes out
        rsp_next.cursor_column = 7'(cur_x);
        rsp_next.cursor_row    = 5'(cur_y);
        rsp_next.cell_char     = ctl_reg.rd ? ram_rdata[7:0] : 8'd0;
        rsp_next.cell_colour   = ctl_reg.rd ? ram_rdata[15:8] : 8'd0;
        rsp_next.scrolled      = ctl_reg.scroll;

        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== sv/tcw_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/tcw_cursor.sv =====
// Cursor registers and per-request decode: target cell, write data, cursor motion.
module tcw_cursor #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tcw_pkg::cmd_t                    cmd,
    input  logic                             update,
    output tcw_pkg::ctl_t                    ctl,
    output logic [$clog2(COLUMNS*ROWS)-1:0]  addr,
    output logic [15:0]                      wr_data,
    output logic [$clog2(COLUMNS)-1:0]       cur_x,
    output logic [$clog2(ROWS)-1:0]          cur_y
);

    localparam int XW    = $clog2(COLUMNS);
    localparam int YW    = $clog2(ROWS);
    localparam int IDX_W = $clog2(COLUMNS * ROWS);

    logic [XW-1:0] cur_x_reg, cur_x_next;
    logic [YW-1:0] cur_y_reg, cur_y_next;
    logic [XW-1:0] col_cl, tgt_x;
    logic [YW-1:0] row_cl, tgt_y, down_y;
    logic          at_bottom;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg <= '0;
            cur_y_reg <= '0;
        end
        else if (update)
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
        end
    end

    always_comb
    begin
        col_cl = ({1'b0, cmd.column} >= 8'(COLUMNS)) ? XW'(COLUMNS - 1) : XW'(cmd.column);
        row_cl = ({2'b0, cmd.row} >= 7'(ROWS)) ? YW'(ROWS - 1) : YW'(cmd.row);
        at_bottom = (cur_y_reg == YW'(ROWS - 1));
        down_y = at_bottom ? cur_y_reg : cur_y_reg + YW'(1);

        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        tgt_x      = cur_x_reg;
        tgt_y      = cur_y_reg;
        ctl        = '0;
        wr_data    = {cmd.colour, cmd.char_code};

        unique case (cmd.opcode)
            tcw_pkg::OP_WRITE:
            begin
                priority if (cmd.char_code == tcw_pkg::CH_NEWLINE)
                begin
                    cur_x_next = '0;
                    cur_y_next = down_y;
                    ctl.sweep  = at_bottom;
                    ctl.scroll = at_bottom;
                end
                else if (cmd.char_code == tcw_pkg::CH_BACKSPACE)
                begin
                    // top-left stays on row 0, wrapping to its last column
                    if (cur_x_reg == '0)
                    begin
                        cur_x_next = XW'(COLUMNS - 1);
                        cur_y_next = (cur_y_reg != '0) ? cur_y_reg - YW'(1) : cur_y_reg;
                    end
                    else
                    begin
                        cur_x_next = cur_x_reg - XW'(1);
                    end
                    tgt_x   = cur_x_next;
                    tgt_y   = cur_y_next;
                    wr_data = {tcw_pkg::BS_COLOUR, tcw_pkg::CH_SPACE};
                    ctl.wr  = 1'b1;
                end
                else
                begin
                    ctl.wr = 1'b1;
                    if (cur_x_reg == XW'(COLUMNS - 1))
                    begin
                        cur_x_next = '0;
                        cur_y_next = down_y;
                        ctl.sweep  = at_bottom;
                        ctl.scroll = at_bottom;
                    end
                    else
                    begin
                        cur_x_next = cur_x_reg + XW'(1);
                    end
                end
            end
            tcw_pkg::OP_CLEAR:
            begin
                ctl.sweep = 1'b1;
            end
            tcw_pkg::OP_SETCUR:
            begin
                cur_x_next = col_cl;
                cur_y_next = row_cl;
            end
            tcw_pkg::OP_READ:
            begin
                tgt_x  = col_cl;
                tgt_y  = row_cl;
                ctl.rd = 1'b1;
            end
        endcase

        addr = IDX_W'(tgt_y) * IDX_W'(COLUMNS) + IDX_W'(tgt_x);
    end

    assign cur_x = cur_x_reg;
    assign cur_y = cur_y_reg;

endmodule

// ===== verif/console_checker.sv =====
// Response checker for the text console write engine: cell store predictor and comparison.
module console_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  logic cmd_ready,
    input  cmd_t cmd,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   fail_count,
    output int   pending,
    output int   scroll_count
);

    localparam int CELLS = COLUMNS * ROWS;

    // char in the low byte, colour in the high byte
    logic [15:0] screen [CELLS];
    int unsigned cur_col;
    int unsigned cur_row;
    rsp_t        due_rsp_q [$];

    function automatic int unsigned clamp(int unsigned v, int unsigned lim);
        return (v >= lim) ? lim - 1 : v;
    endfunction

    task automatic line_feed(output logic did_scroll);
        did_scroll = 1'b0;
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS)
        begin
            cur_row = ROWS - 1;
            for (int i = 0; i < CELLS - COLUMNS; i++)
                screen[i] = screen[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                screen[i] = '0;
            did_scroll = 1'b1;
        end
    endtask

    task automatic predict_rsp(input cmd_t c, output rsp_t r);
        logic        sc;
        logic [15:0] v;
        r  = '0;
        sc = 1'b0;
        case (c.opcode)
            OP_WRITE:
            begin
                if (c.char_code == CH_NEWLINE)
                begin
                    line_feed(sc);
                end
                else if (c.char_code == CH_BACKSPACE)
                begin
                    // column 0 goes to the row above; top left stays on row 0
                    if (cur_col == 0)
                    begin
                        cur_col = COLUMNS;
                        if (cur_row > 0)
                            cur_row--;
                    end
                    cur_col--;
                    screen[cur_row * COLUMNS + cur_col] = {BS_COLOUR, CH_SPACE};
                end
                else
                begin
                    screen[cur_row * COLUMNS + cur_col] = {c.colour, c.char_code};
                    cur_col++;
                    if (cur_col >= COLUMNS)
                        line_feed(sc);
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen[i][7:0] = CH_SPACE;
            end
            OP_SETCUR:
            begin
                cur_col = clamp(c.column, COLUMNS);
                cur_row = clamp(c.row, ROWS);
            end
            default:
            begin
                v = screen[clamp(c.row, ROWS) * COLUMNS + clamp(c.column, COLUMNS)];
                r.cell_char   = v[7:0];
                r.cell_colour = v[15:8];
            end
        endcase
        r.cursor_column = cur_col[6:0];
        r.cursor_row    = cur_row[4:0];
        r.scrolled      = sc;
    endtask

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
                screen[i] = '0;
            cur_col = 0;
            cur_row = 0;
            due_rsp_q.delete();
            fail_count   = 0;
            pending      = 0;
            scroll_count = 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                predict_rsp(cmd, want);
                due_rsp_q.push_back(want);
                if (want.scrolled)
                    scroll_count++;
            end
            if (rsp_valid && rsp_ready)
            begin
                if (due_rsp_q.size() == 0)
                begin
                    $error("response with no request outstanding: %p", rsp);
                    fail_count++;
                end
                else
                begin
                    want = due_rsp_q.pop_front();
                    compare_field("cursor_column", want.cursor_column, rsp.cursor_column);
                    compare_field("cursor_row", want.cursor_row, rsp.cursor_row);
                    compare_field("cell_char", want.cell_char, rsp.cell_char);
                    compare_field("cell_colour", want.cell_colour, rsp.cell_colour);
                    compare_field("scrolled", want.scrolled, rsp.scrolled);
                end
            end
            pending = due_rsp_q.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the text console write engine: stimulus, handshake idling and verdict.
module tb_top;
    import tcw_pkg::*;

    localparam int IDLE_LIMIT   = 20000;
    localparam int TOTAL_ITEMS  = 850;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    int fail_count;
    int pending;
    int scroll_count;
    int sent;
    int clears_sent;
    int reads_sent;
    int idle_cycles;
    int stall_left;
    bit send_calm;
    bit rsp_calm;

    text_console_write_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    console_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp),
        .fail_count   (fail_count),
        .pending      (pending),
        .scroll_count (scroll_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic cmd_t make_cmd(op_t op, logic [7:0] ch, logic [7:0] col,
                                      logic [6:0] x, logic [4:0] y);
        cmd_t c;
        c.opcode    = op;
        c.char_code = ch;
        c.colour    = col;
        c.column    = x;
        c.row       = y;
        return c;
    endfunction

    function automatic cmd_t rnd_cmd(op_t op);
        return make_cmd(op, 8'($urandom), 8'($urandom), 7'($urandom), 5'($urandom));
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so a back-to-back request never toggles it.
    task automatic send(input cmd_t c);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        @(negedge clk);
        sent++;
        if (c.opcode == OP_CLEAR)
            clears_sent++;
        if (c.opcode == OP_READ)
            reads_sent++;
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (stall_left == 0 && !rsp_calm && $urandom_range(0, 3) == 0)
            stall_left = pick_gap(1'b0);
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $error("no request or response moved for %0d cycles", IDLE_LIMIT);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        cmd_t        c;
        int          n;
        int          pick;
        int          r;
        int unsigned base_col;
        int unsigned base_row;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: corners, clamping, wrap, scroll, backspace edges, clear
        send(make_cmd(OP_READ, 8'h00, 8'h00, 7'd0, 5'd0));
        send(make_cmd(OP_READ, 8'hFF, 8'hFF, 7'h7F, 5'h1F));
        send(make_cmd(OP_SETCUR, 8'hFF, 8'hFF, 7'h7F, 5'h1F));
        send(make_cmd(OP_WRITE, 8'h41, 8'hFF, 7'd0, 5'd0));     // last cell: wrap and scroll
        send(make_cmd(OP_READ, 8'h00, 8'h00, 7'd79, 5'd23));
        send(make_cmd(OP_WRITE, CH_BACKSPACE, 8'h00, 7'd0, 5'd0));
        send(make_cmd(OP_READ, 8'h00, 8'h00, 7'd79, 5'd23));
        send(make_cmd(OP_SETCUR, 8'h00, 8'h00, 7'd0, 5'd0));
        send(make_cmd(OP_WRITE, CH_BACKSPACE, 8'hFF, 7'h7F, 5'h1F)); // top left
        send(make_cmd(OP_WRITE, 8'hFF, 8'hAA, 7'd0, 5'd0));
        send(make_cmd(OP_WRITE, 8'h00, 8'h01, 7'd0, 5'd0));
        send(make_cmd(OP_WRITE, CH_NEWLINE, 8'h00, 7'd0, 5'd0));
        send(make_cmd(OP_READ, 8'h00, 8'h00, 7'd79, 5'd0));
        send(make_cmd(OP_SETCUR, 8'h00, 8'h00, 7'd80, 5'd25));
        send(make_cmd(OP_SETCUR, 8'h00, 8'h00, 7'd79, 5'd24));
        send(make_cmd(OP_WRITE, 8'h7E, 8'h55, 7'd0, 5'd0));
        send(make_cmd(OP_WRITE, CH_NEWLINE, 8'h00, 7'd0, 5'd0));  // scroll by newline
        send(make_cmd(OP_CLEAR, 8'hFF, 8'hFF, 7'h7F, 5'h1F));
        send(make_cmd(OP_READ, 8'h00, 8'h00, 7'd79, 5'd23));
        send(make_cmd(OP_READ, 8'h00, 8'h00, 7'd0, 5'd0));
        send(make_cmd(OP_READ, 8'h00, 8'h00, 7'd0, 5'd24));
        wait_drained();

        while (sent < TOTAL_ITEMS)
        begin
            send_calm = ($urandom_range(0, 3) == 0);
            rsp_calm  = ($urandom_range(0, 4) == 0);
            pick      = $urandom_range(0, 99);
            if (pick < 60)
            begin
                // place the cursor, type a line of text, read some of it back
                base_col = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                       : $urandom_range(0, 79);
                base_row = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 31)
                                                      : $urandom_range(0, 20);
                c = rnd_cmd(OP_SETCUR);
                c.column = 7'(base_col);
                c.row    = 5'(base_row);
                send(c);
                n = $urandom_range(1, 16);
                repeat (n)
                begin
                    c = rnd_cmd(OP_WRITE);
                    r = $urandom_range(0, 99);
                    if (r < 12)
                        c.char_code = CH_NEWLINE;
                    else if (r < 25)
                        c.char_code = CH_BACKSPACE;
                    send(c);
                end
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    c = rnd_cmd(OP_READ);
                    c.column = 7'(base_col + $urandom_range(0, 15));
                    c.row    = 5'(base_row + $urandom_range(0, 1));
                    send(c);
                end
            end
            else if (pick < 82)
            begin
                // loose requests of any kind; clears kept rare as each walks the store
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    c = rnd_cmd(op_t'($urandom_range(0, 3)));
                    if (c.opcode == OP_CLEAR && $urandom_range(0, 4) != 0)
                        c.opcode = OP_READ;
                    send(c);
                end
            end
            else if (pick < 86)
            begin
                send(rnd_cmd(OP_CLEAR));
            end
            else if (pick < 95)
            begin
                // text straight after wherever the cursor was left
                n = $urandom_range(1, 10);
                repeat (n)
                begin
                    c = rnd_cmd(OP_WRITE);
                    if ($urandom_range(0, 5) == 0)
                        c.char_code = CH_NEWLINE;
                    send(c);
                end
            end
            else
            begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (50) @(negedge clk);

        $display("Sent %0d requests: %0d cell reads and %0d clears; %0d scrolls predicted.",
                 sent, reads_sent, clears_sent, scroll_count);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
